// ===== hw/rtl/eop_pkg.sv =====
// ----------------------------------------------------------------------------
// eop_pkg: shared types and constants for the EDNS0 OPT record parser
// Beat and result layouts, parse phases, verdict codes and header offsets.
// ----------------------------------------------------------------------------
package eop_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_OPTHDR = 2'd2,
    PH_SKIP   = 2'd3
  } eop_phase_e;

  typedef enum logic [2:0] {
    V_SUCCESS = 3'd0,
    V_PRIVATE = 3'd1,
    V_TYPE    = 3'd2,
    V_VERSION = 3'd3,
    V_LENGTH  = 3'd4
  } eop_verdict_e;

  // Fixed header byte offsets
  localparam logic [3:0] HdrOwner   = 4'd0;
  localparam logic [3:0] HdrTypeHi  = 4'd1;
  localparam logic [3:0] HdrTypeLo  = 4'd2;
  localparam logic [3:0] HdrVersion = 4'd6;
  localparam logic [3:0] HdrRdlenHi = 4'd9;
  localparam logic [3:0] HdrRdlenLo = 4'd10;

  // Option header byte offsets
  localparam logic [1:0] OptCodeHi = 2'd0;
  localparam logic [1:0] OptCodeLo = 2'd1;
  localparam logic [1:0] OptLenHi  = 2'd2;
  localparam logic [1:0] OptLenLo  = 2'd3;

  localparam logic [15:0] MinSection    = 16'd11;
  localparam logic [15:0] OptType       = 16'd41;
  localparam logic [15:0] OptHdrLen     = 16'd4;
  localparam logic [15:0] PrivCodeReset = 16'd65001;
  localparam logic [3:0]  RdlenOffset   = 4'd9;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_req;
    logic [15:0] section_length;
  } eop_beat_t;

  typedef struct packed {
    eop_verdict_e verdict;
    logic [15:0]  consumed_bytes;
    logic [3:0]   rdlen_offset;
  } eop_result_t;

endpackage

// ===== hw/rtl/eop_if.sv =====
// ----------------------------------------------------------------------------
// eop_in_if / eop_out_if: valid/ready channels of the OPT record parser
// Input channel carries section bytes, output channel carries verdicts.
// ----------------------------------------------------------------------------
interface eop_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        start_req;
  logic [15:0] section_length;

  modport source (output valid, output data_byte, output start_req,
                  output section_length, input ready);
  modport sink   (input valid, input data_byte, input start_req,
                  input section_length, output ready);
endinterface

interface eop_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [15:0] consumed_bytes;
  logic [3:0]  rdlen_offset;

  modport source (output valid, output verdict, output consumed_bytes,
                  output rdlen_offset, input ready);
  modport sink   (input valid, input verdict, input consumed_bytes,
                  input rdlen_offset, output ready);
endinterface

// ===== hw/rtl/edns_opt_record_parser_top.sv =====
// ----------------------------------------------------------------------------
// edns_opt_record_parser_top: EDNS0 OPT record parser
// Byte-serial parser of a DNS additional section giving at most one verdict a record.
// ----------------------------------------------------------------------------
// Feed the additional section one byte per beat, start_req set on the owner
// byte together with the section length. Each record yields one verdict
// beat (success, private option, bad owner/type, bad version, bad length)
// on the byte that decides it, none if a new start cuts it short; bytes
// after a verdict and bytes with no open record are swallowed without
// output. Throughput is one byte per cycle unless the verdict register
// stalls: a beat lands in an input register, the parse step runs as
// compares and 16-bit add/subtract, and a verdict goes to an output
// register once the step fires. When the verdict register is stalled the
// input register still takes one more beat before ready drops. The private
// option code register resets to 65001 and is written by cfg_we_i /
// cfg_wdata_i; the user must write it only while the parser is quiet,
// and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module edns_opt_record_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  eop_in_if.sink      in_i,
  eop_out_if.source   out_o
);
  import eop_pkg::*;

  logic        in_valid_q, in_valid_d;
  eop_beat_t   beat_q;
  logic [15:0] priv_code_q;
  logic        out_free;
  logic        step;
  logic        res_valid;
  eop_result_t res;

  // private option code register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      priv_code_q <= PrivCodeReset;
    end else if (cfg_we_i) begin
      priv_code_q <= cfg_wdata_i;
    end
  end

  // input stage: the parse step fires when a beat is held and the verdict slot can take a result
  assign step       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;
  assign in_valid_d = (in_i.valid && in_i.ready) ? 1'b1 : (in_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      beat_q.data_byte      <= in_i.data_byte;
      beat_q.start_req      <= in_i.start_req;
      beat_q.section_length <= in_i.section_length;
    end
  end

  eop_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .beat_i      (beat_q),
    .priv_code_i (priv_code_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  eop_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step && res_valid),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

  a_verdict_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res_valid |=> out_o.valid)
    else $error("verdict lost between parse and output register");

endmodule

// ===== hw/rtl/eop_parse.sv =====
// ----------------------------------------------------------------------------
// eop_parse: parse state and per-beat next-state / verdict logic
// Advances the OPT record parse by one byte each step.
// ----------------------------------------------------------------------------
module eop_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  eop_pkg::eop_beat_t  beat_i,
  input  logic [15:0]         priv_code_i,
  output logic                res_valid_o,
  output eop_pkg::eop_result_t res_o
);
  import eop_pkg::*;

  eop_phase_e  phase_q, phase_d;
  logic [3:0]  hidx_q, hidx_d;
  logic [15:0] rdrem_q, rdrem_d;
  logic [15:0] code_q, code_d;
  logic [15:0] olen_q, olen_d;
  logic [15:0] bcnt_q, bcnt_d;
  logic [15:0] sect_q, sect_d;
  logic        owner_bad_q, owner_bad_d;

  // effective state after a possible start
  eop_phase_e  ph;
  logic [3:0]  hidx;
  logic [15:0] rdrem, code, olen, bcnt, sect;
  logic        owner_bad;
  logic [15:0] code_new, len_new, rd_after_hdr, rd_after_opt, room, olen_dec;
  logic [1:0]  oidx;
  logic [7:0]  b;

  always_comb begin
    b         = beat_i.data_byte;
    ph        = beat_i.start_req ? PH_HEADER : phase_q;
    hidx      = beat_i.start_req ? 4'd0 : hidx_q;
    rdrem     = beat_i.start_req ? 16'd0 : rdrem_q;
    code      = beat_i.start_req ? 16'd0 : code_q;
    olen      = beat_i.start_req ? 16'd0 : olen_q;
    bcnt      = beat_i.start_req ? 16'd0 : bcnt_q;
    sect      = beat_i.start_req ? beat_i.section_length : sect_q;
    owner_bad = beat_i.start_req ? 1'b0 : owner_bad_q;

    code_new     = {code[7:0], b};
    len_new      = {olen[7:0], b};
    room         = sect - MinSection;
    rd_after_hdr = rdrem - OptHdrLen;
    rd_after_opt = rd_after_hdr - len_new;
    olen_dec     = (olen != 16'd0) ? olen - 16'd1 : olen;
    oidx         = hidx[1:0];

    phase_d     = ph;
    hidx_d      = hidx;
    rdrem_d     = rdrem;
    code_d      = code;
    olen_d      = olen;
    bcnt_d      = bcnt;
    sect_d      = sect;
    owner_bad_d = owner_bad;

    res_valid_o          = 1'b0;
    res_o.verdict        = V_SUCCESS;
    res_o.consumed_bytes = bcnt + 16'd1;
    res_o.rdlen_offset   = RdlenOffset;

    if (beat_i.start_req && (beat_i.section_length < MinSection)) begin
      res_valid_o          = 1'b1;
      res_o.verdict        = V_LENGTH;
      res_o.consumed_bytes = 16'd0;
      res_o.rdlen_offset   = 4'd0;
      phase_d              = PH_IDLE;
    end else if (ph != PH_IDLE) begin
      bcnt_d = bcnt + 16'd1;
      case (ph)
        PH_HEADER: begin
          hidx_d = hidx + 4'd1;
          res_o.rdlen_offset = 4'd0;
          case (hidx)
            HdrOwner:  owner_bad_d = (b != 8'd0);
            HdrTypeHi: code_d = {8'd0, b};
            HdrTypeLo: begin
              code_d = code_new;
              if (owner_bad || (code_new != OptType)) begin
                res_valid_o   = 1'b1;
                res_o.verdict = V_TYPE;
              end
            end
            HdrVersion: begin
              if (b != 8'd0) begin
                res_valid_o   = 1'b1;
                res_o.verdict = V_VERSION;
              end
            end
            HdrRdlenHi: rdrem_d = {8'd0, b};
            HdrRdlenLo: begin
              rdrem_d            = {rdrem[7:0], b};
              res_o.rdlen_offset = RdlenOffset;
              if ({rdrem[7:0], b} == 16'd0) begin
                res_valid_o = 1'b1;
              end else if ({rdrem[7:0], b} > room) begin
                res_valid_o   = 1'b1;
                res_o.verdict = V_LENGTH;
              end else if ({rdrem[7:0], b} < OptHdrLen) begin
                res_valid_o = 1'b1;
              end else begin
                phase_d = PH_OPTHDR;
                hidx_d  = 4'd0;
              end
            end
            default: ;
          endcase
        end
        PH_OPTHDR: begin
          hidx_d = {2'b00, oidx + 2'd1};
          case (oidx)
            OptCodeHi: code_d = {8'd0, b};
            OptCodeLo: code_d = code_new;
            OptLenHi:  olen_d = {8'd0, b};
            OptLenLo: begin
              olen_d  = len_new;
              rdrem_d = rd_after_hdr;
              if (rd_after_hdr < len_new) begin
                res_valid_o   = 1'b1;
                res_o.verdict = V_LENGTH;
              end else if (code == priv_code_i) begin
                res_valid_o          = 1'b1;
                res_o.verdict        = V_PRIVATE;
                res_o.consumed_bytes = bcnt + 16'd1 + len_new;
              end else begin
                rdrem_d = rd_after_opt;
                if (len_new == 16'd0) begin
                  if (rd_after_opt < OptHdrLen) res_valid_o = 1'b1;
                end else begin
                  phase_d = PH_SKIP;
                end
              end
            end
            default: ;
          endcase
        end
        PH_SKIP: begin
          olen_d = olen_dec;
          if (olen_dec == 16'd0) begin
            if (rdrem < OptHdrLen) begin
              res_valid_o = 1'b1;
            end else begin
              phase_d = PH_OPTHDR;
              hidx_d  = 4'd0;
            end
          end
        end
        default: ;
      endcase
      if (res_valid_o) phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hidx_q      <= 4'd0;
      rdrem_q     <= 16'd0;
      code_q      <= 16'd0;
      olen_q      <= 16'd0;
      bcnt_q      <= 16'd0;
      sect_q      <= 16'd0;
      owner_bad_q <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      hidx_q      <= hidx_d;
      rdrem_q     <= rdrem_d;
      code_q      <= code_d;
      olen_q      <= olen_d;
      bcnt_q      <= bcnt_d;
      sect_q      <= sect_d;
      owner_bad_q <= owner_bad_d;
    end
  end

  a_header_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> sect_q >= MinSection)
    else $error("header phase with short section");

  a_opthdr_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_OPTHDR |-> rdrem_q >= OptHdrLen)
    else $error("option header phase without room for a header");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> olen_q != 16'd0)
    else $error("skip phase with nothing left to skip");

  a_hdr_verdict_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && (res_o.verdict == V_TYPE || res_o.verdict == V_VERSION)
    |-> res_o.rdlen_offset == 4'd0)
    else $error("early header verdict carries RDATA offset");

endmodule

// ===== hw/rtl/eop_out_reg.sv =====
// ----------------------------------------------------------------------------
// eop_out_reg: verdict output register
// Holds one verdict until the sink takes it; free when empty or draining.
// ----------------------------------------------------------------------------
module eop_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  eop_pkg::eop_result_t res_i,
  output logic                 free_o,
  eop_out_if.source            out_o
);
  import eop_pkg::*;

  logic        valid_q, valid_d;
  eop_result_t res_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i ? 1'b1 : (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.verdict        = res_q.verdict;
  assign out_o.consumed_bytes = res_q.consumed_bytes;
  assign out_o.rdlen_offset   = res_q.rdlen_offset;

endmodule

// ===== verif/edns_opt_record_parser_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edns_opt_record_parser_top_test: self-checking bench for the OPT parser
// Streams DNS additional-section bytes into the parser, predicts each verdict
// with a bit-exact parser model kept here, and compares every verdict beat.
// ----------------------------------------------------------------------------
module edns_opt_record_parser_top_test;
  import eop_pkg::*;

  localparam int StallLimit  = 2000;  // cycles with no beat moving on either side
  localparam int HoldCycles  = 300;   // long receiver hold-off, fills the parser
  localparam int DrainCycles = 4;     // margin to empty the input and verdict registers
  localparam int PhaseBeats  = 250;   // beats sent per random phase

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  eop_in_if  in_if ();
  eop_out_if out_if ();

  edns_opt_record_parser_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Parser model state. Mirrors the block: phase, header/option byte index,
  // RDATA left, code/type shift register, option length left, byte counter,
  // sampled section length, owner flag and the private option code register.
  // --------------------------------------------------------------------------
  eop_phase_e  p_phase;
  logic [3:0]  p_hidx;
  logic [15:0] p_rdleft;
  logic [15:0] p_code;
  logic [15:0] p_optleft;
  logic [15:0] p_count;
  logic [15:0] p_sect;
  logic        p_owner_nz;
  logic [15:0] p_priv;

  eop_result_t pending_verdicts[$];  // verdicts owed by the parser, oldest first
  int          err_cnt;
  int          parsed_beats;         // beats accepted by the parser
  int          snd_idle_pct;
  int          rcv_stall_pct;
  int          hold_asked;
  int          hold_taken;
  logic [7:0]  rec_bytes[$];         // record under construction

  typedef struct {
    logic        start;
    logic [15:0] sect;
    logic [7:0]  data;
    bit          given;
    eop_result_t want;
  } stim_row_t;

  stim_row_t dir_tab[$];

  int          snd_plan[4] = '{0, 68, 0, 21};
  int          rcv_plan[4] = '{0, 0, 68, 21};
  logic [15:0] priv_plan[4];

  function automatic eop_result_t mk_verdict(input eop_verdict_e v, input logic [15:0] c,
                                             input logic [3:0] o);
    eop_result_t x;
    x.verdict        = v;
    x.consumed_bytes = c;
    x.rdlen_offset   = o;
    return x;
  endfunction

  function automatic void parser_reset();
    p_phase    = PH_IDLE;
    p_hidx     = '0;
    p_rdleft   = '0;
    p_code     = '0;
    p_optleft  = '0;
    p_count    = '0;
    p_sect     = '0;
    p_owner_nz = 1'b0;
    p_priv     = PrivCodeReset;
  endfunction

  // One byte through the parser model; returns 1 when this byte decides the
  // record, with the verdict in r.
  function automatic bit opt_parse_step(input logic [7:0] d, input logic st,
                                        input logic [15:0] sl, output eop_result_t r);
    bit         hit;
    logic [3:0] idx;
    logic [1:0] oi;
    hit = 1'b0;
    r   = '0;
    if (st) begin
      // a start drops whatever record was open, with no verdict for it
      p_sect     = sl;
      p_count    = '0;
      p_hidx     = '0;
      p_rdleft   = '0;
      p_code     = '0;
      p_optleft  = '0;
      p_owner_nz = 1'b0;
      p_phase    = PH_HEADER;
      // short section: refused on the start byte, nothing consumed
      if (sl < MinSection) begin
        hit = 1'b1;
        r   = mk_verdict(V_LENGTH, 16'd0, 4'd0);
      end
    end
    if (!hit && p_phase != PH_IDLE) begin
      p_count = p_count + 16'd1;
      case (p_phase)
        PH_HEADER: begin
          idx    = p_hidx;
          p_hidx = p_hidx + 4'd1;
          case (idx)
            HdrOwner:  p_owner_nz = (d != 8'h00);
            HdrTypeHi: p_code = {8'h00, d};
            HdrTypeLo: begin
              p_code = {p_code[7:0], d};
              if (p_owner_nz || p_code != OptType) begin
                hit = 1'b1;
                r   = mk_verdict(V_TYPE, p_count, 4'd0);
              end
            end
            HdrVersion: begin
              if (d != 8'h00) begin
                hit = 1'b1;
                r   = mk_verdict(V_VERSION, p_count, 4'd0);
              end
            end
            HdrRdlenHi: p_rdleft = {8'h00, d};
            HdrRdlenLo: begin
              p_rdleft = {p_rdleft[7:0], d};
              hit = 1'b1;
              if (p_rdleft == 16'd0) begin
                r = mk_verdict(V_SUCCESS, p_count, RdlenOffset);
              end else if (p_rdleft > p_sect - MinSection) begin
                r = mk_verdict(V_LENGTH, p_count, RdlenOffset);
              end else if (p_rdleft < OptHdrLen) begin
                r = mk_verdict(V_SUCCESS, p_count, RdlenOffset);
              end else begin
                hit     = 1'b0;
                p_phase = PH_OPTHDR;
                p_hidx  = '0;
              end
            end
            default: ;
          endcase
        end
        PH_OPTHDR: begin
          oi     = p_hidx[1:0];
          p_hidx = {2'b00, oi + 2'd1};
          case (oi)
            OptCodeHi: p_code = {8'h00, d};
            OptCodeLo: p_code = {p_code[7:0], d};
            OptLenHi:  p_optleft = {8'h00, d};
            OptLenLo: begin
              p_optleft = {p_optleft[7:0], d};
              p_rdleft  = p_rdleft - OptHdrLen;
              if (p_rdleft < p_optleft) begin
                hit = 1'b1;
                r   = mk_verdict(V_LENGTH, p_count, RdlenOffset);
              end else if (p_code == p_priv) begin
                // private match also owns the option value bytes
                hit = 1'b1;
                r   = mk_verdict(V_PRIVATE, p_count + p_optleft, RdlenOffset);
              end else begin
                p_rdleft = p_rdleft - p_optleft;
                if (p_optleft == 16'd0) begin
                  if (p_rdleft < OptHdrLen) begin
                    hit = 1'b1;
                    r   = mk_verdict(V_SUCCESS, p_count, RdlenOffset);
                  end
                end else begin
                  p_phase = PH_SKIP;
                end
              end
            end
            default: ;
          endcase
        end
        PH_SKIP: begin
          if (p_optleft != 16'd0) p_optleft = p_optleft - 16'd1;
          if (p_optleft == 16'd0) begin
            if (p_rdleft < OptHdrLen) begin
              hit = 1'b1;
              r   = mk_verdict(V_SUCCESS, p_count, RdlenOffset);
            end else begin
              p_phase = PH_OPTHDR;
              p_hidx  = '0;
            end
          end
        end
        default: ;
      endcase
    end
    if (hit) p_phase = PH_IDLE;
    return hit;
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("%0t MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Sender. Random idle cycles before each beat, then hold the beat until the
  // parser takes it. The prediction runs at the accepting edge; a directed
  // row may carry its verdict typed in, which then stands in for the model.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] d, input logic st, input logic [15:0] sl,
                           input bit given, input eop_result_t gv);
    eop_result_t pr;
    bit          got;
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= d;
    in_if.start_req      <= st;
    in_if.section_length <= sl;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    parsed_beats++;
    got = opt_parse_step(d, st, sl, pr);
    if (given) pending_verdicts.push_back(gv);
    else if (got) pending_verdicts.push_back(pr);
  endtask

  function automatic void row(input logic st, input logic [15:0] sl, input logic [7:0] d);
    stim_row_t s;
    s.start = st;
    s.sect  = sl;
    s.data  = d;
    s.given = 1'b0;
    s.want  = '0;
    dir_tab.push_back(s);
  endfunction

  function automatic void row_v(input logic st, input logic [15:0] sl, input logic [7:0] d,
                                input eop_verdict_e v, input logic [15:0] c,
                                input logic [3:0] o);
    stim_row_t s;
    s.start = st;
    s.sect  = sl;
    s.data  = d;
    s.given = 1'b1;
    s.want  = mk_verdict(v, c, o);
    dir_tab.push_back(s);
  endfunction

  function automatic void push_word(input logic [15:0] w);
    rec_bytes.push_back(w[15:8]);
    rec_bytes.push_back(w[7:0]);
  endfunction

  // 11-byte fixed header; class, extended rcode and flags are noise
  function automatic void push_header(input logic [7:0] owner, input logic [15:0] typ,
                                      input logic [7:0] ver, input logic [15:0] rdlen);
    rec_bytes.push_back(owner);
    push_word(typ);
    push_word(16'($urandom));
    rec_bytes.push_back(8'($urandom));
    rec_bytes.push_back(ver);
    push_word(16'($urandom));
    push_word(rdlen);
  endfunction

  // Mostly well-formed records with random options; the rest hit each
  // failure: short section, bad owner/type, bad version, and huge RDATA or
  // option lengths that reach the high bits of every length field.
  task automatic build_record(output logic [15:0] sect);
    int          kind;
    int          nopt;
    int          olen;
    logic [15:0] code;
    logic [15:0] wlen;
    logic [15:0] rdlen;
    logic [7:0]  opts[$];
    rec_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 6) begin
      sect = 16'($urandom_range(10));
      rec_bytes.push_back(8'($urandom));
    end else if (kind < 14) begin
      sect = 16'($urandom);
      push_header($urandom_range(1) ? 8'($urandom) : 8'h00,
                  $urandom_range(1) ? OptType : 16'($urandom), 8'($urandom), 16'($urandom));
    end else if (kind < 20) begin
      sect = 16'($urandom_range(11, 65535));
      push_header(8'h00, OptType, 8'($urandom_range(1, 255)), 16'($urandom));
    end else if (kind < 30) begin
      // big lengths: beyond-section, overrun or a private match far away
      sect = $urandom_range(1) ? 16'hFFFF : 16'($urandom);
      push_header(8'h00, OptType, 8'h00, 16'($urandom));
      push_word($urandom_range(1) ? p_priv : 16'($urandom));
      push_word(16'($urandom));
    end else begin
      nopt = $urandom_range(4);
      for (int n = 0; n < nopt; n++) begin
        code = ($urandom_range(3) == 0) ? p_priv : 16'($urandom);
        olen = $urandom_range(6);
        wlen = 16'(olen);
        if ($urandom_range(24) == 0) wlen = wlen + 16'($urandom_range(1, 400));
        opts.push_back(code[15:8]);
        opts.push_back(code[7:0]);
        opts.push_back(wlen[15:8]);
        opts.push_back(wlen[7:0]);
        repeat (olen) opts.push_back(8'($urandom));
      end
      // short tail left unread
      repeat ($urandom_range(3)) opts.push_back(8'($urandom));
      rdlen = 16'(opts.size());
      sect  = MinSection + rdlen + 16'($urandom_range(3));
      if (rdlen != 16'd0 && $urandom_range(9) == 0) sect = MinSection + rdlen - 16'd1;
      push_header(8'h00, OptType, 8'h00, rdlen);
      foreach (opts[k]) rec_bytes.push_back(opts[k]);
    end
  endtask

  task automatic send_record();
    logic [15:0] sect;
    int          cut;
    build_record(sect);
    cut = rec_bytes.size();
    // now and then the next start cuts this record short
    if ($urandom_range(19) == 0) cut = $urandom_range(1, cut);
    for (int i = 0; i < cut; i++)
      send_beat(rec_bytes[i], i == 0, (i == 0) ? sect : 16'($urandom), 1'b0, '0);
    // stray bytes with no record open
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 1'b0, 16'($urandom), 1'b0, '0);
  endtask

  // Pause the sender until every owed verdict is in, then let the pipe empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_priv(input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    p_priv = v;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request so the input
  // side backs up and ready drops.
  // --------------------------------------------------------------------------
  initial begin : recv_side
    int hold_left;
    hold_left    = 0;
    hold_taken   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_taken) begin
        hold_taken = hold_asked;
        hold_left  = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Verdict checker: every beat out must match the oldest owed verdict
  always @(posedge clk_i) begin
    eop_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("verdict with none pending", {13'd0, out_if.verdict}, 16'd0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_if.verdict !== want.verdict)
          flag_mismatch("verdict", {13'd0, out_if.verdict}, {13'd0, want.verdict});
        if (out_if.consumed_bytes !== want.consumed_bytes)
          flag_mismatch("consumed_bytes", out_if.consumed_bytes, want.consumed_bytes);
        if (out_if.rdlen_offset !== want.rdlen_offset)
          flag_mismatch("rdlen_offset", {12'd0, out_if.rdlen_offset},
                        {12'd0, want.rdlen_offset});
      end
    end
  end

  // Watchdog: too long with no beat moving on either channel ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit pressed;
    int target;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    in_if.valid          = 1'b0;
    in_if.data_byte      = '0;
    in_if.start_req      = 1'b0;
    in_if.section_length = '0;
    err_cnt              = 0;
    parsed_beats         = 0;
    snd_idle_pct         = 0;
    rcv_stall_pct        = 0;
    hold_asked           = 0;
    pressed              = 1'b0;
    priv_plan            = '{16'h0000, 16'hFFFF, 16'($urandom), PrivCodeReset};
    parser_reset();

    // Directed rows. Typed verdicts are the ones that follow from the header
    // layout alone; the rest must give nothing and are left to the model.
    // short section, extreme byte
    row_v(1'b1, 16'd0, 8'hFF, V_LENGTH, 16'd0, 4'd0);
    // byte with no record open
    row(1'b0, 16'hFFFF, 8'h00);
    // nonzero owner, largest section: type error on the third byte
    row(1'b1, 16'hFFFF, 8'hFF);
    row(1'b0, 16'h0000, 8'h00);
    row_v(1'b0, 16'h0000, 8'h29, V_TYPE, 16'd3, 4'd0);
    // record abandoned by a new start after two bytes
    row(1'b1, 16'd11, 8'h00);
    row(1'b0, 16'd11, 8'h00);
    // bad version on the seventh byte
    row(1'b1, 16'd11, 8'h00);
    row(1'b0, 16'd0, 8'h00);
    row(1'b0, 16'd0, 8'h29);
    row(1'b0, 16'd0, 8'h00);
    row(1'b0, 16'd0, 8'h01);
    row(1'b0, 16'd0, 8'h00);
    row_v(1'b0, 16'd0, 8'h80, V_VERSION, 16'd7, 4'd0);
    // minimal section with one RDATA byte: RDATA runs past the section
    row(1'b1, 16'd11, 8'h00);
    row(1'b0, 16'd0, 8'h00);
    row(1'b0, 16'd0, 8'h29);
    row(1'b0, 16'd0, 8'h00);
    row(1'b0, 16'd0, 8'h01);
    row(1'b0, 16'd0, 8'hFF);
    row(1'b0, 16'd0, 8'h00);
    row(1'b0, 16'd0, 8'h80);
    row(1'b0, 16'd0, 8'h00);
    row(1'b0, 16'd0, 8'h00);
    row_v(1'b0, 16'd0, 8'h01, V_LENGTH, 16'd11, RdlenOffset);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_beat(dir_tab[i].data, dir_tab[i].start, dir_tab[i].sect,
                dir_tab[i].given, dir_tab[i].want);

    // Random phases: each changes the private code while quiet, then runs
    // with its own idle/stall mix. Phase 0 has no idling at all and carries
    // the long receiver hold-off.
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_priv(priv_plan[ph]);
      snd_idle_pct  = snd_plan[ph];
      rcv_stall_pct = rcv_plan[ph];
      target        = parsed_beats + PhaseBeats;
      while (parsed_beats < target) begin
        if (ph == 0 && !pressed && parsed_beats > target - PhaseBeats / 2) begin
          hold_asked++;
          pressed = 1'b1;
        end
        send_record();
      end
    end

    settle();
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
